/* hdl/assert_macros.svh */
// Assertion macros shared by the window statistics RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define WMS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define WMS_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* hdl/wms_pkg.sv */
// Shared types and constants for the window mean and deviation unit.
package wms_pkg;

	localparam int WINDOW_DEF      = 32;
	localparam int SAMPLE_BITS_DEF = 10;
	localparam int MEAN_BITS       = 10;
	localparam int STD_BITS        = 9;
	localparam int QUEUE_DEPTH     = 4;

	typedef enum logic {
		OP_STORE   = 1'b0,
		OP_MEASURE = 1'b1
	} op_t;

	typedef struct packed {
		logic avail;
		op_t  op;
	} wms_head_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUM,
		ST_DIV_MEAN,
		ST_DEV,
		ST_DIV_VAR,
		ST_SQRT,
		ST_DONE
	} back_state_t;

endpackage

/* hdl/wms_cdiv.sv */
// Divider by a constant divisor: a shift for a power of two, else a reciprocal multiply.
module wms_cdiv import wms_pkg::*; #(
	parameter int DIVISOR = WINDOW_DEF,
	parameter int W       = 25
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quot
);

	localparam bit POW2   = ((DIVISOR & (DIVISOR - 1)) == 0);
	localparam int SHIFT  = $clog2(DIVISOR);
	localparam int S      = W + SHIFT;
	localparam int MW     = W + 1;
	localparam int CH     = 16;
	localparam int NCH    = (W + CH - 1) / CH;
	localparam int XW     = NCH * CH;
	localparam int PW     = XW + MW;
	localparam int PRW    = CH + MW;
	localparam int STEP_W = $clog2(NCH + 1);
	localparam longint unsigned RECIP =
		((64'd1 << S) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [W-1:0]      quot_q;
	logic [XW-1:0]     x_q;
	logic [PW-1:0]     prod_q;
	logic [CH-1:0]     digit;
	logic [PRW-1:0]    part;
	logic [PW-1:0]     prod_nx;
	logic              last;

	always_comb begin
		digit   = x_q[XW-1 -: CH];
		part    = PRW'(digit) * PRW'(RECIP_M);
		prod_nx = (prod_q << CH) + PW'(part);
	end

	assign last = (step_q == STEP_W'(NCH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !POW2;
				done_q <= POW2;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= POW2 ? (dividend >> SHIFT) : '0;
			x_q    <= XW'(dividend);
			prod_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << CH;
			prod_q <= prod_nx;
			if (last) quot_q <= W'(prod_nx >> S);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule

/* hdl/wms_sqrt.sv */
// Sequential integer square root, one root bit per cycle.
module wms_sqrt import wms_pkg::*; #(
	parameter int RW = SAMPLE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*RW-1:0] radicand,
	output logic            done,
	output logic [RW-1:0]   root
);

	localparam int SW = $clog2(RW);

	logic            busy_q;
	logic            done_q;
	logic [SW-1:0]   step_q;
	logic [2*RW-1:0] x_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [RW+3:0]   rem_t;
	logic [RW+3:0]   trial;
	logic            fit;
	logic [RW+3:0]   rem_d;

	always_comb begin
		rem_t = {rem_q, x_q[2*RW-1:2*RW-2]};
		trial = (RW+4)'({root_q, 2'b01});
		fit   = (rem_t >= trial);
		rem_d = fit ? (rem_t - trial) : rem_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(RW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= rem_d[RW+1:0];
			root_q <= {root_q[RW-2:0], fit};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* hdl/wms_front.sv */
// Request intake: input register, opcode decode and word queue.
`include "assert_macros.svh"

module wms_front import wms_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic                   opcode,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   clearing,
	input  logic                   pop,
	output wms_head_t              head,
	output logic [SAMPLE_BITS-1:0] head_sample
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                   vld_s1;
	op_t                    op_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	op_t                    q_op_q  [QUEUE_DEPTH];
	logic [SAMPLE_BITS-1:0] q_smp_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   space;
	logic                   push;
	logic                   load;

	assign space     = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign push      = vld_s1 && space;
	assign req_stall = clearing || (vld_s1 && !space);
	assign load      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (load) begin
				vld_s1 <= 1'b1;
			end else if (push) begin
				vld_s1 <= 1'b0;
			end
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_s1  <= opcode ? OP_MEASURE : OP_STORE;
			smp_s1 <= sample;
		end
		if (push) begin
			q_op_q[wr_ptr_q]  <= op_s1;
			q_smp_q[wr_ptr_q] <= smp_s1;
		end
	end

	assign head.avail  = (cnt_q != '0);
	assign head.op     = q_op_q[rd_ptr_q];
	assign head_sample = q_smp_q[rd_ptr_q];

	`WMS_NEVER(a_queue_bound, cnt_q > CNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
	`WMS_NEVER(a_pop_empty, pop && (cnt_q == '0), "pop from empty queue")
	`WMS_NEVER(a_take_in_clear, clearing && load, "word taken during clearing pass")

endmodule

/* hdl/wms_back.sv */
// Execution: sample ring, sum and deviation passes, divide, root, result register.
`include "assert_macros.svh"

module wms_back import wms_pkg::*; #(
	parameter int WINDOW      = WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wms_head_t              head,
	input  logic [SAMPLE_BITS-1:0] head_sample,
	output logic                   pop,
	output logic                   clearing,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic [MEAN_BITS-1:0]   mean,
	output logic [STD_BITS-1:0]    std_dev
);

	localparam int IDX_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
	localparam int ACC_W = 2 * SAMPLE_BITS + $clog2(WINDOW);
	localparam int VAR_W = 2 * SAMPLE_BITS;

	back_state_t            state_q;
	back_state_t            state_d;
	logic [IDX_W-1:0]       wp_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
	logic                   vld_s1;
	logic                   vld_s2;
	logic                   vld_s3;
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic [SAMPLE_BITS-1:0] dev_s2;
	logic [VAR_W-1:0]       sq_s3;
	logic [SUM_W-1:0]       sum_q;
	logic [ACC_W-1:0]       acc_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic                   res_valid_q;
	logic [MEAN_BITS-1:0]   mean_out_q;
	logic [STD_BITS-1:0]    std_out_q;

	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [SAMPLE_BITS-1:0] mem_wdata;
	logic [IDX_W-1:0]       rd_addr;
	logic                   issue;
	logic                   pass_end;
	logic                   clear_last;
	logic                   out_free;
	logic                   out_load;
	logic                   div_start;
	logic [ACC_W-1:0]       div_in;
	logic                   div_busy;
	logic                   div_done;
	logic [ACC_W-1:0]       div_quot;
	logic                   sqrt_start;
	logic                   sqrt_done;
	logic [SAMPLE_BITS-1:0] sqrt_root;
	logic [SAMPLE_BITS+MEAN_BITS-1:0] mean_ext;
	logic [SAMPLE_BITS+STD_BITS-1:0]  root_ext;

	wms_cdiv #(
		.DIVISOR (WINDOW),
		.W       (ACC_W)
	) u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot)
	);

	wms_sqrt #(
		.RW (SAMPLE_BITS)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quot[VAR_W-1:0]),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	assign rd_addr    = cnt_q[IDX_W-1:0];
	assign issue      = ((state_q == ST_SUM) || (state_q == ST_DEV)) &&
	                    (cnt_q != CNT_W'(WINDOW));
	assign pass_end   = (cnt_q == CNT_W'(WINDOW)) && !vld_s1 && !vld_s2 && !vld_s3;
	assign clear_last = (cnt_q == CNT_W'(WINDOW - 1));
	assign out_free   = !res_valid_q || !res_stall;
	assign div_in     = (state_q == ST_SUM) ? ACC_W'(sum_q) : acc_q;
	assign mean_ext   = {{MEAN_BITS{1'b0}}, mean_q};
	assign root_ext   = {{STD_BITS{1'b0}}, sqrt_root};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (head.avail && (head.op == OP_MEASURE)) state_d = ST_SUM;
			end
			ST_SUM: begin
				if (pass_end) state_d = ST_DIV_MEAN;
			end
			ST_DIV_MEAN: begin
				if (div_done) state_d = ST_DEV;
			end
			ST_DEV: begin
				if (pass_end) state_d = ST_DIV_VAR;
			end
			ST_DIV_VAR: begin
				if (div_done) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (sqrt_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = wp_q;
		mem_wdata  = head_sample;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		out_load   = 1'b0;
		clearing   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clearing  = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = cnt_q[IDX_W-1:0];
				mem_wdata = '0;
			end
			ST_IDLE: begin
				if (head.avail) begin
					pop    = 1'b1;
					mem_we = (head.op == OP_STORE);
				end
			end
			ST_SUM: begin
				div_start = pass_end;
			end
			ST_DEV: begin
				div_start = pass_end;
			end
			ST_DIV_VAR: begin
				sqrt_start = div_done;
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			wp_q        <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			vld_s2  <= vld_s1 && (state_q == ST_DEV);
			vld_s3  <= vld_s2;
			if (pop && (head.op == OP_STORE)) begin
				wp_q <= (wp_q == IDX_W'(WINDOW - 1)) ? '0 : wp_q + 1'b1;
			end
			case (state_q)
				ST_CLEAR:    cnt_q <= clear_last ? '0 : cnt_q + 1'b1;
				ST_IDLE:     cnt_q <= '0;
				ST_DIV_MEAN: cnt_q <= '0;
				default: begin
					if (issue) cnt_q <= cnt_q + 1'b1;
				end
			endcase
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) ring_mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		dev_s2 <= (rd_data_s1 >= mean_q) ? (rd_data_s1 - mean_q) : (mean_q - rd_data_s1);
		sq_s3  <= VAR_W'(dev_s2) * VAR_W'(dev_s2);
		if (state_q == ST_IDLE) begin
			sum_q <= '0;
		end else if (vld_s1 && (state_q == ST_SUM)) begin
			sum_q <= sum_q + SUM_W'(rd_data_s1);
		end
		if (state_q == ST_DIV_MEAN) begin
			acc_q <= '0;
			if (div_done) mean_q <= div_quot[SAMPLE_BITS-1:0];
		end else if (vld_s3) begin
			acc_q <= acc_q + ACC_W'(sq_s3);
		end
		if (out_load) begin
			mean_out_q <= mean_ext[MEAN_BITS-1:0];
			std_out_q  <= root_ext[STD_BITS-1:0];
		end
	end

	assign res_valid = res_valid_q;
	assign mean      = mean_out_q;
	assign std_dev   = std_out_q;

	`WMS_NEVER(a_pop_idle, pop && (state_q != ST_IDLE), "word taken outside idle")
	`WMS_ASSERT(a_wp_store, !$stable(wp_q) |-> $past(pop && (head.op == OP_STORE)), "pointer moved without store")
	`WMS_ASSERT(a_div_free, div_start |-> !div_busy, "divider started while busy")
	`WMS_NEVER(a_clear_quiet, clearing && (pop || res_valid_q), "activity during clearing pass")

endmodule

/* hdl/window_mean_stddev_unit.sv */
// Sliding window mean and population standard deviation unit, top level.
// Store words (opcode 0) write one sample into a WINDOW-entry ring and give no result;
// measure words (opcode 1) give one result, floor(sum/WINDOW) as mean and
// floor(sqrt(floor(sum of squared deviations/WINDOW))) as std_dev. After reset the ring
// is cleared to zero with req_stall high. A store is written to the ring when it is popped in
// the idle state. A measure makes two passes over the ring, a sum pass and a deviation pass,
// runs the one-bit-per-cycle square root, and uses the constant divider (a shift for a
// power-of-two WINDOW, else a reciprocal multiply taken 16 bits a cycle). A four-word queue
// lets stores be taken while a measure runs or a result waits on res_stall.
module window_mean_stddev_unit import wms_pkg::*; #(
	parameter int WINDOW      = WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  logic                   opcode,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   res_valid,
	input  logic                   res_stall,
	output logic [MEAN_BITS-1:0]   mean,
	output logic [STD_BITS-1:0]    std_dev
);

	wms_head_t              head;
	logic [SAMPLE_BITS-1:0] head_sample;
	logic                   pop;
	logic                   clearing;

	wms_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.opcode      (opcode),
		.sample      (sample),
		.clearing    (clearing),
		.pop         (pop),
		.head        (head),
		.head_sample (head_sample)
	);

	wms_back #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_sample (head_sample),
		.pop         (pop),
		.clearing    (clearing),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.mean        (mean),
		.std_dev     (std_dev)
	);

endmodule
